@@ src/ptpu_pkg.sv @@
`timescale 1ns / 1ps

package ptpu_pkg;

    localparam int WORDS_W = 16;
    localparam int PIX_W   = 32;

    localparam logic [6:0]         ROOT_NODE   = 7'd2;
    localparam logic [WORDS_W-1:0] WORDS_RESET = 16'd1536;

    typedef enum logic [1:0] {
        CMD_TREE_WR = 2'd0,
        CMD_SYM_WR  = 2'd1,
        CMD_BYTE    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOKUP = 2'd1,
        S_STEP   = 2'd2,
        S_EMIT   = 2'd3
    } state_t;

    // Each 2-bit pair of the symbol becomes one pixel byte, lowest pair first.
    function automatic logic [PIX_W-1:0] expand_symbol(input logic [7:0] sym);
        logic [PIX_W-1:0] word;
        word = '0;
        for (int j = 0; j < 4; j++) begin
            word[8*j +: 8] = {3'b000, sym[2*j+1], 3'b000, sym[2*j]};
        end
        return word;
    endfunction

endpackage

@@ src/prefix_tree_pixel_unpacker.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// s_       in         s_tvalid / s_tready      s_tdata, s_tuser (command)
// m_       out        m_tvalid / m_tready      m_tdata (pixel word), m_tlast
// cfg_     in         cfg_valid / cfg_ready    cfg_data (total_words)
//
// Table writes and restart are done on acceptance. A compressed byte is accepted,
// then each bit takes a tree memory read step and a node update step, and each
// emitted word adds an emit step; the tree read is registered.
// Once the frame is complete the byte ends at its next lookup step (its first, if so on entry).
// A stalled output register holds the walk in the emit step; s_tready is low
// for the whole byte. aresetn is synchronous, active low; tables are not cleared.

module prefix_tree_pixel_unpacker #(
    parameter int TREE_ENTRIES   = 256,
    parameter int SYMBOL_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] table_index, [15:8] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] pixel_word
    output logic        m_tlast,    // last_word

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // total_words
);

    import ptpu_pkg::*;

    localparam int TREE_AW = $clog2(TREE_ENTRIES);
    localparam int SYM_AW  = $clog2(SYMBOL_ENTRIES);

    state_t state_reg, state_next;

    logic [6:0]         node_reg, node_next;
    logic [2:0]         bit_reg, bit_next;
    logic [7:0]         byte_reg, byte_next;
    logic [WORDS_W-1:0] words_reg, words_next;
    logic [WORDS_W-1:0] total_reg;
    logic [PIX_W-1:0]   out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_valid_reg, out_valid_next;

    logic [7:0] tree_mem [TREE_ENTRIES];
    logic [7:0] sym_mem  [SYMBOL_ENTRIES];
    logic [7:0] tree_q_reg, sym_q_reg;
    logic       tree_ok_reg, sym_ok_reg;

    logic        s_accept;
    cmd_t        cmd;
    logic [7:0]  table_index;
    logic [7:0]  data_byte;
    logic [7:0]  look_addr;
    logic [7:0]  tree_val;
    logic        is_branch;
    logic [7:0]  sym_addr;
    logic        out_free;
    logic        done;

    assign cmd         = cmd_t'(s_tuser);
    assign table_index = s_tdata[7:0];
    assign data_byte   = s_tdata[15:8];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign look_addr = {1'b0, node_reg} + {7'd0, byte_reg[bit_reg]};
    assign tree_val  = tree_ok_reg ? tree_q_reg : 8'd0;
    assign is_branch = !tree_val[7] && (tree_val != 8'd0);
    assign sym_addr  = ~tree_val + 8'd1;
    assign out_free  = !out_valid_reg || m_tready;
    assign done      = (words_reg >= total_reg);

    // Table memories: written from the input channel, read with registered data.
    always_ff @(posedge aclk) begin
        if (s_accept && cmd == CMD_TREE_WR && {1'b0, table_index} < 9'(TREE_ENTRIES)) begin
            tree_mem[table_index[TREE_AW-1:0]] <= data_byte;
        end
        if (s_accept && cmd == CMD_SYM_WR && {1'b0, table_index} < 9'(SYMBOL_ENTRIES)) begin
            sym_mem[table_index[SYM_AW-1:0]] <= data_byte;
        end
        tree_q_reg  <= tree_mem[look_addr[TREE_AW-1:0]];
        tree_ok_reg <= ({1'b0, look_addr} < 9'(TREE_ENTRIES));
        // hold the symbol while the emit step waits on the output register
        if (state_reg == S_STEP) begin
            sym_q_reg  <= sym_mem[sym_addr[SYM_AW-1:0]];
            sym_ok_reg <= ({1'b0, sym_addr} < 9'(SYMBOL_ENTRIES));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            node_reg      <= ROOT_NODE;
            bit_reg       <= '0;
            words_reg     <= '0;
            total_reg     <= WORDS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            bit_reg       <= bit_next;
            words_reg     <= words_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        node_next      = node_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        words_next     = words_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (cmd)
                        CMD_BYTE: begin
                            byte_next  = data_byte;
                            bit_next   = '0;
                            state_next = S_LOOKUP;
                        end
                        CMD_RESTART: begin
                            node_next  = ROOT_NODE;
                            words_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOKUP: begin
                // drop the rest of the byte once the frame is complete
                state_next = done ? S_IDLE : S_STEP;
            end
            S_STEP: begin
                if (is_branch) begin
                    node_next  = tree_val[6:0];
                    bit_next   = bit_reg + 3'd1;
                    state_next = (bit_reg == 3'd7) ? S_IDLE : S_LOOKUP;
                end else begin
                    node_next  = ROOT_NODE;
                    words_next = words_reg + 16'd1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_data_next  = expand_symbol(sym_ok_reg ? sym_q_reg : 8'd0);
                    out_last_next  = (words_reg == total_reg);
                    out_valid_next = 1'b1;
                    bit_next       = bit_reg + 3'd1;
                    state_next     = (bit_reg == 3'd7) ? S_IDLE : S_LOOKUP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_EMIT))
        else $error("output register loaded outside the emit step");

    a_leaf_returns_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP && !is_branch) |=> (node_reg == ROOT_NODE && state_reg == S_EMIT))
        else $error("leaf did not restart the walk at the root");

    a_byte_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd == CMD_BYTE) |=> (state_reg == S_LOOKUP && bit_reg == 3'd0))
        else $error("compressed byte did not start at its lowest bit");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ptpu_pkg::*;

    typedef struct {
        logic [31:0] pixel;
        logic        last;
    } pix_due_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cmd_t        cmd;
        logic [7:0]  idx;
        logic [7:0]  dat;
        logic [15:0] limit;
        int          typed_n;
        logic [31:0] typed_word;
    } script_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] table_index, [15:8] data_byte
    logic [1:0]  s_tuser   = '0;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] pixel_word
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // Predictor state
    logic [7:0]  tree_img [0:255];
    logic [7:0]  sym_img  [0:255];
    bit          tree_set [0:255];
    bit          sym_set  [0:255];
    int          walk_node;
    logic [15:0] words_out;
    logic [15:0] word_limit;

    pix_due_t    words_due [$];
    script_row_t script [$];
    int          err_count   = 0;
    int          fed         = 0;
    int          choke_asked = 0;
    bit          calm        = 1'b0;

    prefix_tree_pixel_unpacker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 9);
    endfunction

    function automatic logic [31:0] pixels_of(input logic [7:0] sym);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            case (sym[2*j +: 2])
                2'd0:    w[8*j +: 8] = 8'h00;
                2'd1:    w[8*j +: 8] = 8'h01;
                2'd2:    w[8*j +: 8] = 8'h10;
                default: w[8*j +: 8] = 8'h11;
            endcase
        end
        return w;
    endfunction

    // Walk one stream byte, lowest bit first; queue the words if asked.
    task automatic walk_byte(input logic [7:0] b, input bit emit);
        logic signed [7:0] hop;
        pix_due_t          due;
        for (int k = 0; k < 8; k++) begin
            if (words_out < word_limit) begin
                hop = tree_img[walk_node + int'(b[k])];
                if (hop > 0) begin
                    walk_node = hop;
                end else begin
                    walk_node = ROOT_NODE;
                    words_out = words_out + 16'd1;
                    due.pixel = pixels_of(sym_img[-int'(hop)]);
                    due.last  = (words_out == word_limit);
                    if (emit)
                        words_due.push_back(due);
                end
            end
        end
    endtask

    // Tree entry that keeps every walk on written entries: a leaf to a written
    // symbol, or a hop to a node whose two children are both written.
    function automatic logic [7:0] safe_tree_val();
        int hops[$];
        int leafs[$];
        for (int p = 1; p < 128; p++)
            if (tree_set[p] && tree_set[p+1])
                hops.push_back(p);
        for (int s = 0; s <= 128; s++)
            if (sym_set[s])
                leafs.push_back(s);
        if (hops.size() > 0 && $urandom_range(9) < 4)
            return 8'(hops[$urandom_range(hops.size() - 1)]);
        return 8'(-leafs[$urandom_range(leafs.size() - 1)]);
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [7:0] idx, input logic [7:0] dat,
                             input int typed_n, input logic [31:0] typed_word);
        pix_due_t due;
        @(negedge aclk);
        while (idle_roll()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dat, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        fed++;
        case (cmd)
            CMD_TREE_WR: begin
                tree_img[idx] = dat;
                tree_set[idx] = 1'b1;
            end
            CMD_SYM_WR: begin
                sym_img[idx] = dat;
                sym_set[idx] = 1'b1;
            end
            CMD_RESTART: begin
                walk_node = ROOT_NODE;
                words_out = '0;
            end
            default: begin
                walk_byte(dat, typed_n < 0);
                due.pixel = typed_word;
                due.last  = 1'b0;
                for (int i = 0; i < typed_n; i++)
                    words_due.push_back(due);
            end
        endcase
    endtask

    // Hold the input until every word is out, then let a wordless byte finish.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        word_limit = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan_item(input cmd_t cmd, input logic [7:0] idx,
                                      input logic [7:0] dat, input int n,
                                      input logic [31:0] w);
        script_row_t r;
        r.kind       = ROW_ITEM;
        r.cmd        = cmd;
        r.idx        = idx;
        r.dat        = dat;
        r.limit      = '0;
        r.typed_n    = n;
        r.typed_word = w;
        script.push_back(r);
    endfunction

    function automatic void plan_limit(input logic [15:0] v);
        script_row_t r;
        r.kind       = ROW_CFG;
        r.cmd        = CMD_BYTE;
        r.idx        = '0;
        r.dat        = '0;
        r.limit      = v;
        r.typed_n    = -1;
        r.typed_word = '0;
        script.push_back(r);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin : rx_side
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(negedge aclk);
            if (choke_asked != seen) begin
                seen      = choke_asked;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idle_roll();
            end
        end
    end

    always @(posedge aclk) begin : word_check
        pix_due_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (words_due.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected word: got %h last %b", m_tdata, m_tlast);
            end else begin
                due = words_due.pop_front();
                if (m_tdata !== due.pixel || m_tlast !== due.last) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("word mismatch: expected %h last %b, got %h last %b",
                                 due.pixel, due.last, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin : stimulus
        script_row_t r;
        int          ph;
        logic [7:0]  t_idx;

        walk_node  = ROOT_NODE;
        words_out  = '0;
        word_limit = WORDS_RESET;

        // Symbols 0 and 128 back the two root leaves; 255 only exercises the index.
        plan_item(CMD_SYM_WR,  8'd0,   8'h00, -1, '0);
        plan_item(CMD_SYM_WR,  8'd128, 8'hFF, -1, '0);
        plan_item(CMD_SYM_WR,  8'd255, 8'hE4, -1, '0);
        plan_item(CMD_SYM_WR,  8'd1,   8'h1B, -1, '0);
        plan_item(CMD_TREE_WR, 8'd2,   8'h00, -1, '0);
        plan_item(CMD_TREE_WR, 8'd3,   8'h80, -1, '0);
        plan_item(CMD_BYTE,    8'h00,  8'h00,  8, 32'h0000_0000);
        plan_item(CMD_BYTE,    8'hFF,  8'hFF,  8, 32'h1111_1111);
        plan_item(CMD_BYTE,    8'h3C,  8'hA5, -1, '0);
        // Deeper tree: root bit 1 hops to node 4, node 4 bit 0 hops to node 127.
        plan_item(CMD_TREE_WR, 8'd255, 8'h00, -1, '0);
        plan_item(CMD_TREE_WR, 8'd127, 8'hFF, -1, '0);
        plan_item(CMD_TREE_WR, 8'd128, 8'h80, -1, '0);
        plan_item(CMD_TREE_WR, 8'd4,   8'h7F, -1, '0);
        plan_item(CMD_TREE_WR, 8'd5,   8'hFF, -1, '0);
        plan_item(CMD_TREE_WR, 8'd3,   8'h04, -1, '0);
        plan_item(CMD_BYTE,    8'h00,  8'h5A, -1, '0);
        plan_item(CMD_BYTE,    8'h00,  8'hC3, -1, '0);
        // Limit already passed: bytes are dropped until a restart.
        plan_limit(16'd3);
        plan_item(CMD_BYTE,    8'h00,  8'hFF,  0, '0);
        plan_item(CMD_RESTART, 8'hFF,  8'hFF, -1, '0);
        plan_item(CMD_BYTE,    8'h00,  8'h00, -1, '0);
        plan_item(CMD_BYTE,    8'h00,  8'hFF,  0, '0);
        plan_item(CMD_RESTART, 8'h00,  8'h00, -1, '0);
        plan_limit(16'hFFFF);
        plan_item(CMD_BYTE,    8'h00,  8'h00,  8, 32'h0000_0000);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            r = script[i];
            if (r.kind == ROW_CFG)
                set_limit(r.limit);
            else
                send_item(r.cmd, r.idx, r.dat, r.typed_n, r.typed_word);
        end

        ph = 0;
        while (fed < 100) begin
            case (ph % 8)
                1:       set_limit(16'hFFFF);
                2:       set_limit(16'd1);
                3:       set_limit(16'($urandom_range(60, 2)));
                4:       set_limit(16'd0);
                5:       set_limit(16'hFFFF);
                6:       set_limit(16'($urandom_range(20, 1)));
                7:       set_limit(WORDS_RESET);
                default: settle();
            endcase
            calm = (ph % 8 == 0);

            repeat ($urandom_range(6, 3)) begin
                t_idx = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(40, 2));
                send_item(CMD_TREE_WR, t_idx, safe_tree_val(), -1, '0);
            end
            repeat ($urandom_range(2, 1))
                send_item(CMD_SYM_WR, 8'($urandom_range(140)), 8'($urandom), -1, '0);
            // Now and then carry the old walk into the new phase.
            if ($urandom_range(6) != 0)
                send_item(CMD_RESTART, 8'($urandom), 8'($urandom), -1, '0);

            if (ph % 8 == 1)
                choke_asked++;

            repeat ((ph % 8 == 1) ? 14 : $urandom_range(12, 6)) begin
                if ($urandom_range(99) < 8) begin
                    case ($urandom_range(2))
                        0: send_item(CMD_RESTART, 8'($urandom), 8'($urandom), -1, '0);
                        1: send_item(CMD_TREE_WR, 8'($urandom_range(40, 2)),
                                     safe_tree_val(), -1, '0);
                        default: send_item(CMD_SYM_WR, 8'($urandom_range(140)),
                                           8'($urandom), -1, '0);
                    endcase
                end else begin
                    send_item(CMD_BYTE, 8'($urandom), 8'($urandom), -1, '0);
                end
            end
            ph++;
        end

        calm = 1'b0;
        settle();
        if (err_count == 0 && words_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ptpu_pkg.sv
src/prefix_tree_pixel_unpacker.sv
sim/tb.sv
